// ----- hw/rtl/dpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_pkg: shared types and constants of the demand paging controller
// Field widths, register indexes, result codes, sequencer states and the
// replacement LFSR step.
// ----------------------------------------------------------------------------
package dpc_pkg;

  localparam int ADDR_W      = 16;
  localparam int LIMIT_W     = 8;
  localparam int SEED_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam int DEF_PAGE_COUNT  = 128;
  localparam int DEF_FRAME_COUNT = 16;
  localparam int DEF_PAGE_BYTES  = 32;

  localparam logic [SEED_W-1:0] SEED_RESET = 16'h0001;
  localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TEXT_LIMIT,
    CFG_BSS_LIMIT,
    CFG_RANDOM_SEED
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_CODE_STORE,
    ST_UNALLOC
  } status_t;

  typedef enum logic [1:0] {
    FS_NONE,
    FS_EXEC,
    FS_SWAP,
    FS_ZERO
  } fill_src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_OWNER,
    S_EVICT,
    S_FILL
  } state_t;

  // per-page flags held in the page table
  typedef struct packed {
    logic valid;
    logic dirty;
  } pt_flags_t;

  // one step of the Galois replacement LFSR
  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
    logic [SEED_W-1:0] shifted;
    shifted = v >> 1;
    return v[0] ? (shifted ^ LFSR_TAPS) : shifted;
  endfunction

endpackage

// ----- hw/rtl/dpc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_if: request and response channels of the demand paging controller
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface dpc_req_if import dpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              mode;

  modport source (output valid, output address, output mode, input ready);
  modport sink   (input valid, input address, input mode, output ready);
endinterface

interface dpc_rsp_if import dpc_pkg::*; #(
  parameter int PAGE_W = $clog2(DEF_PAGE_COUNT),
  parameter int PA_W   = $clog2(DEF_FRAME_COUNT * DEF_PAGE_BYTES)
) ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              hit;
  logic [PA_W-1:0]   physical_address;
  logic [1:0]        fill_source;
  logic [PAGE_W-1:0] fill_page;
  logic              evict_valid;
  logic [PAGE_W-1:0] evicted_page;
  logic              write_back;

  modport source (
    output valid, output status, output hit, output physical_address,
    output fill_source, output fill_page, output evict_valid,
    output evicted_page, output write_back, input ready
  );
  modport sink (
    input valid, input status, input hit, input physical_address,
    input fill_source, input fill_page, input evict_valid,
    input evicted_page, input write_back, output ready
  );
endinterface

// ----- hw/rtl/demand_paging_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_paging_controller: virtual to physical translation with paging
// Page table and frame owner map in synchronous memories; misses take the
// next free frame or an LFSR-chosen victim, with eviction and write-back.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+-----------------------------------------
//  cfg     | in  | cfg_write      | cfg_index, cfg_data (no read-back)
//  req     | in  | valid / ready  | address, mode
//  rsp     | out | valid / ready  | status, hit, physical_address,
//          |     |                | fill_source, fill_page, evict_valid,
//          |     |                | evicted_page, write_back
//
//  A hit or an error passes S_IDLE and S_LOOK; a miss into a free frame adds
//  S_FILL, and a miss with replacement adds S_OWNER and S_EVICT before it.
//  The page table is read once for the page and once for the evicted owner, then written.
//  Reset clears control state, limits to zero and the LFSR to 1; page table
//  entries read as zero until written, so no clearing pass is needed.
//  A result sits in the output register until taken; a new request is
//  accepted meanwhile, and the next result waits in its final state.
// ----------------------------------------------------------------------------
module demand_paging_controller import dpc_pkg::*; #(
  parameter int PAGE_COUNT  = DEF_PAGE_COUNT,
  parameter int FRAME_COUNT = DEF_FRAME_COUNT,
  parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  dpc_req_if.sink                req,
  dpc_rsp_if.source              rsp
);

  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int CNT_W   = $clog2(FRAME_COUNT + 1);
  localparam int PA_W    = $clog2(FRAME_COUNT * PAGE_BYTES);
  localparam int CMP_W   = (PAGE_W > LIMIT_W) ? PAGE_W : LIMIT_W;

  // exact division of a 16-bit value by a constant via a rounded reciprocal
  localparam int PB_L    = $clog2(PAGE_BYTES);
  localparam int PB_SH   = ADDR_W + PB_L;
  localparam longint unsigned PB_M = ((64'd1 << PB_SH) / PAGE_BYTES) + 64'd1;
  localparam int PROD_W  = 2 * ADDR_W + 1;
  localparam int Q_W     = $clog2(((2 ** ADDR_W) - 1) / PAGE_BYTES + 1);

  localparam int FR_L    = $clog2(FRAME_COUNT);
  localparam int FR_SH   = SEED_W + FR_L;
  localparam longint unsigned FR_M = ((64'd1 << FR_SH) / FRAME_COUNT) + 64'd1;
  localparam int FPROD_W = 2 * SEED_W + 1;

  state_t state, state_next;

  // request capture
  logic [ADDR_W-1:0]  addr_q;
  logic               store_q;
  logic [Q_W-1:0]     page_q;
  logic [PROD_W-1:0]  page_prod;
  logic [Q_W-1:0]     page_div;
  logic               accept;

  // configuration and replacement LFSR
  logic [LIMIT_W-1:0] text_limit;
  logic [LIMIT_W-1:0] bss_limit;
  logic [SEED_W-1:0]  lfsr;
  logic [SEED_W-1:0]  cand;
  logic [SEED_W-1:0]  cand_q;
  logic [FPROD_W-1:0] lfsr_prod;
  logic [SEED_W-1:0]  lquot_q;
  logic [SEED_W-1:0]  rand_rem;
  logic [FRAME_W-1:0] rand_frame;

  // frame map
  logic [CNT_W-1:0]   used_count;
  logic               frames_full;
  logic [PAGE_W-1:0]  owner_mem [FRAME_COUNT];
  logic [PAGE_W-1:0]  owner_rd;
  logic               own_rd_en;
  logic               own_wr_en;

  // page table port
  logic               pt_rd_en;
  logic [PAGE_W-1:0]  pt_rd_addr;
  logic               pt_wr_en;
  logic [PAGE_W-1:0]  pt_wr_addr;
  pt_flags_t          pt_wr_flags;
  logic [FRAME_W-1:0] pt_wr_frame;
  pt_flags_t          pt_flags;
  logic [FRAME_W-1:0] pt_frame;

  // per-access decisions
  logic [PAGE_W-1:0]  page;
  logic               in_range;
  logic               below_text;
  logic               below_bss;
  logic               evicted_code;
  logic               wb_now;
  logic               look_replace;
  logic               look_miss;
  fill_src_t          look_src;
  logic [FRAME_W-1:0] victim_q;
  logic               evict_q;
  logic [PAGE_W-1:0]  evicted_q;
  logic               wb_q;
  fill_src_t          src_q;
  logic               dirty_old_q;
  logic               fill_commit;

  logic [FRAME_W-1:0] phys_frame;
  logic [31:0]        phys_wide;
  logic [PA_W-1:0]    phys;

  // result and output register
  logic               out_free;
  logic               res_load;
  status_t            res_status;
  logic               res_hit;
  logic [PA_W-1:0]    res_phys;
  fill_src_t          res_src;
  logic [PAGE_W-1:0]  res_fill;
  logic               res_evict;
  logic [PAGE_W-1:0]  res_evicted;
  logic               res_wb;

  logic               out_valid;
  status_t            out_status;
  logic               out_hit;
  logic [PA_W-1:0]    out_phys;
  fill_src_t          out_src;
  logic [PAGE_W-1:0]  out_fill;
  logic               out_evict;
  logic [PAGE_W-1:0]  out_evicted;
  logic               out_wb;

  // split the address into page and offset; next LFSR value and its frame
  assign accept    = req.valid && req.ready;
  assign page_prod = PROD_W'(req.address) * PROD_W'(PB_M);
  assign page_div  = Q_W'(page_prod >> PB_SH);
  assign cand      = lfsr_step(lfsr);
  assign lfsr_prod = FPROD_W'(cand) * FPROD_W'(FR_M);

  assign rand_rem   = cand_q - SEED_W'(lquot_q * SEED_W'(FRAME_COUNT));
  assign rand_frame = rand_rem[FRAME_W-1:0];

  assign page         = PAGE_W'(page_q);
  assign in_range     = 32'(page_q) < 32'(PAGE_COUNT);
  assign below_text   = CMP_W'(page) < CMP_W'(text_limit);
  assign below_bss    = CMP_W'(page) < CMP_W'(bss_limit);
  assign evicted_code = CMP_W'(evicted_q) < CMP_W'(text_limit);
  assign wb_now       = pt_flags.dirty && !evicted_code;
  assign frames_full  = used_count == CNT_W'(FRAME_COUNT);
  assign out_free     = !out_valid || rsp.ready;

  // fill source of a missing page
  always_comb begin
    if (below_text) begin
      look_src = FS_EXEC;
    end else if (pt_flags.dirty) begin
      look_src = FS_SWAP;
    end else if (!below_bss) begin
      look_src = FS_ZERO;
    end else begin
      look_src = FS_EXEC;
    end
  end

  // physical address = address + (frame - page) * page size, modulo width
  assign phys_frame = (state == S_FILL) ? victim_q : pt_frame;
  assign phys_wide  = 32'(addr_q) + (32'(phys_frame) - 32'(page)) * 32'(PAGE_BYTES);
  assign phys       = phys_wide[PA_W-1:0];

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, memory strobes and result
  always_comb begin
    state_next   = state;
    pt_rd_en     = 1'b0;
    pt_rd_addr   = PAGE_W'(page_div);
    pt_wr_en     = 1'b0;
    pt_wr_addr   = page;
    pt_wr_flags  = '{valid: 1'b1, dirty: 1'b1};
    pt_wr_frame  = pt_frame;
    own_rd_en    = 1'b0;
    own_wr_en    = 1'b0;
    look_replace = 1'b0;
    look_miss    = 1'b0;
    fill_commit  = 1'b0;
    res_load     = 1'b0;
    res_status   = ST_OK;
    res_hit      = 1'b0;
    res_phys     = '0;
    res_src      = FS_NONE;
    res_fill     = '0;
    res_evict    = 1'b0;
    res_evicted  = '0;
    res_wb       = 1'b0;
    req.ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = !rst;
        if (req.valid && !rst) begin
          pt_rd_en   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        priority if (!in_range) begin
          res_status = ST_RANGE;
          res_load   = out_free;
        end else if (store_q && below_text) begin
          res_status = ST_CODE_STORE;
          res_load   = out_free;
        end else if (pt_flags.valid) begin
          res_hit  = 1'b1;
          res_phys = phys;
          res_load = out_free;
          pt_wr_en = out_free && store_q;
        end else if (!below_text && !pt_flags.dirty && !below_bss && !store_q) begin
          res_status = ST_UNALLOC;
          res_load   = out_free;
        end else begin
          look_miss = 1'b1;
        end
        if (look_miss) begin
          if (frames_full) begin
            look_replace = 1'b1;
            own_rd_en    = 1'b1;
            state_next   = S_OWNER;
          end else begin
            state_next = S_FILL;
          end
        end else if (res_load) begin
          state_next = S_IDLE;
        end
      end
      S_OWNER: begin
        pt_rd_en   = 1'b1;
        pt_rd_addr = owner_rd;
        state_next = S_EVICT;
      end
      S_EVICT: begin
        pt_wr_en    = 1'b1;
        pt_wr_addr  = evicted_q;
        pt_wr_flags = '{valid: 1'b0, dirty: wb_now};
        pt_wr_frame = '0;
        state_next  = S_FILL;
      end
      S_FILL: begin
        res_phys    = phys;
        res_src     = src_q;
        res_fill    = page;
        res_evict   = evict_q;
        res_evicted = evict_q ? evicted_q : '0;
        res_wb      = wb_q;
        if (out_free) begin
          fill_commit = 1'b1;
          res_load    = 1'b1;
          pt_wr_en    = 1'b1;
          pt_wr_flags = '{valid: 1'b1, dirty: dirty_old_q || store_q};
          pt_wr_frame = victim_q;
          own_wr_en   = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // capture the request and the precomputed replacement candidate
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_q  <= req.address;
      store_q <= req.mode;
      page_q  <= page_div;
      cand_q  <= cand;
      lquot_q <= SEED_W'(lfsr_prod >> FR_SH);
    end
  end

  // hold the miss context for eviction and fill
  always_ff @(posedge clk) begin
    if (look_miss) begin
      victim_q    <= frames_full ? rand_frame : FRAME_W'(used_count);
      evict_q     <= frames_full;
      wb_q        <= 1'b0;
      src_q       <= look_src;
      dirty_old_q <= pt_flags.dirty;
    end
    if (state == S_OWNER) begin
      evicted_q <= owner_rd;
    end
    if (state == S_EVICT) begin
      wb_q <= wb_now;
    end
  end

  // configuration registers and LFSR
  always_ff @(posedge clk) begin
    if (rst) begin
      text_limit <= '0;
      bss_limit  <= '0;
      lfsr       <= SEED_RESET;
    end else begin
      if (cfg_write && cfg_index == CFG_TEXT_LIMIT) begin
        text_limit <= cfg_data[LIMIT_W-1:0];
      end
      if (cfg_write && cfg_index == CFG_BSS_LIMIT) begin
        bss_limit <= cfg_data[LIMIT_W-1:0];
      end
      if (cfg_write && cfg_index == CFG_RANDOM_SEED) begin
        lfsr <= cfg_data[SEED_W-1:0];
      end else if (look_replace) begin
        lfsr <= cand_q;
      end
    end
  end

  // frames are handed out in order until all are used
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (fill_commit && !evict_q) begin
      used_count <= used_count + CNT_W'(1);
    end
  end

  // frame owner memory
  always_ff @(posedge clk) begin
    if (own_wr_en) begin
      owner_mem[victim_q] <= page;
    end
    if (own_rd_en) begin
      owner_rd <= owner_mem[rand_frame];
    end
  end

  dpc_page_table #(
    .PAGE_COUNT (PAGE_COUNT),
    .FRAME_W    (FRAME_W)
  ) u_page_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (pt_rd_en),
    .rd_addr  (pt_rd_addr),
    .wr_en    (pt_wr_en),
    .wr_addr  (pt_wr_addr),
    .wr_flags (pt_wr_flags),
    .wr_frame (pt_wr_frame),
    .rd_flags (pt_flags),
    .rd_frame (pt_frame)
  );

  // output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status  <= res_status;
      out_hit     <= res_hit;
      out_phys    <= res_phys;
      out_src     <= res_src;
      out_fill    <= res_fill;
      out_evict   <= res_evict;
      out_evicted <= res_evicted;
      out_wb      <= res_wb;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_status;
  assign rsp.hit              = out_hit;
  assign rsp.physical_address = out_phys;
  assign rsp.fill_source      = out_src;
  assign rsp.fill_page        = out_fill;
  assign rsp.evict_valid      = out_evict;
  assign rsp.evicted_page     = out_evicted;
  assign rsp.write_back       = out_wb;

  // an error result carries no translation, fill or eviction
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |->
      !rsp.hit && rsp.fill_source == FS_NONE && !rsp.evict_valid &&
      !rsp.write_back && rsp.physical_address == '0)
    else $error("error result carries translation fields");

  // write-back only with an eviction
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.write_back |-> rsp.evict_valid)
    else $error("write-back without eviction");

  // replacement only when every frame is in use
  assert property (@(posedge clk) disable iff (rst)
    state == S_OWNER |-> used_count == CNT_W'(FRAME_COUNT))
    else $error("victim chosen while a frame is free");

  // a loaded result shows up on the response channel
  assert property (@(posedge clk) disable iff (rst)
    res_load |=> rsp.valid)
    else $error("result lost in output register");

endmodule

// ----- hw/rtl/dpc_page_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_page_table: page table memory
// One entry per virtual page (valid, dirty, frame) in a synchronous memory
// with one write and one registered read port. A written bit per entry,
// cleared by reset, makes never-written entries read as zero.
// ----------------------------------------------------------------------------
module dpc_page_table import dpc_pkg::*; #(
  parameter int PAGE_COUNT = DEF_PAGE_COUNT,
  parameter int FRAME_W    = $clog2(DEF_FRAME_COUNT),
  localparam int PAGE_W    = $clog2(PAGE_COUNT)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [PAGE_W-1:0]  rd_addr,
  input  logic               wr_en,
  input  logic [PAGE_W-1:0]  wr_addr,
  input  pt_flags_t          wr_flags,
  input  logic [FRAME_W-1:0] wr_frame,
  output pt_flags_t          rd_flags,
  output logic [FRAME_W-1:0] rd_frame
);

  localparam int WORD_W = FRAME_W + 2;

  logic [WORD_W-1:0]     mem [PAGE_COUNT];
  logic [WORD_W-1:0]     rd_word;
  logic [PAGE_COUNT-1:0] written;
  logic                  rd_written;

  // memory array: write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_flags, wr_frame};
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // track entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  // never-written entries read as the reset value
  assign rd_flags = rd_written ? pt_flags_t'(rd_word[WORD_W-1:FRAME_W]) : '0;
  assign rd_frame = rd_written ? rd_word[FRAME_W-1:0] : '0;

endmodule
